// File: rtl/psu_pkg.sv
// Shared types, codes and helpers for the PNG scanline unfilter unit.
// No dependencies; used by psu_front, psu_recon and the top level.
`timescale 1ns / 1ps
`default_nettype none

package psu_pkg;

  localparam int BYTE_W = 8;
  localparam int BPP_W  = 4;
  localparam int ROW_W  = 13;

  localparam logic [BPP_W-1:0] BPP_RESET = 4'd4;
  localparam logic [ROW_W-1:0] ROW_RESET = 13'd1024;

  // Register index (byte address / 4)
  localparam logic REG_BPP = 1'b0;
  localparam logic REG_ROW = 1'b1;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  // Kind of word held in the reconstruct stage
  typedef enum logic [1:0] {
    OP_CLEAR,   // good filter byte: clear histories, no result
    OP_ERROR,   // bad filter byte: error result
    OP_DATA     // filtered data byte: one pixel byte
  } psu_op_t;

  typedef struct packed {
    psu_op_t op;
    filt_t   filter;
    logic    first;   // first row of image: above byte reads as zero
    logic    last;    // final byte of the row
  } psu_s1_t;

  function automatic logic [BYTE_W-1:0] paeth_pick(input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] b,
                                                   input logic [BYTE_W-1:0] c);
    logic signed [10:0] sa, sb, sc, p, pa, pb, pc;
    sa = signed'({3'b000, a});
    sb = signed'({3'b000, b});
    sc = signed'({3'b000, c});
    p  = sa + sb - sc;
    pa = p - sa;
    pb = p - sb;
    pc = p - sc;
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) return a;
    else if (pb <= pc) return b;
    else return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/psu_front.sv
// Front-end sequencer: row position, filter type, halt state and the stage register.
// Depends on psu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psu_front #(
  parameter int MAX_ROW_BYTES = 4096,
  parameter int MAX_BPP       = 8,
  parameter int CW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1,
  parameter int IW = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [psu_pkg::BYTE_W-1:0]     in_byte,
  input  wire                            in_start,
  input  wire  [psu_pkg::BPP_W-1:0]      bytes_per_pixel,
  input  wire  [psu_pkg::ROW_W-1:0]      row_bytes,
  input  wire                            s1_adv,
  output logic                           accept,
  output logic [CW-1:0]                  rd_addr,
  output logic                           s1_valid,
  output psu_pkg::psu_s1_t               s1_info,
  output logic [IW-1:0]                  s1_k,
  output logic [CW-1:0]                  s1_col
);

  localparam int LW = (CW + 1 > psu_pkg::ROW_W) ? CW + 1 : psu_pkg::ROW_W;

  logic [CW-1:0]          column, column_next;
  logic                   on_first_row, on_first_row_next;
  psu_pkg::filt_t         row_filter, row_filter_next;
  logic                   awaiting_filter, awaiting_filter_next;
  logic                   halted, halted_next;
  logic [IW-1:0]          kcnt [MAX_BPP];

  logic                   keep, kclear, kadv, is_last;
  psu_pkg::psu_op_t       op_new;
  logic [psu_pkg::BPP_W-1:0] bpp_eff;
  logic [LW-1:0]          len_eff, col_p1;
  logic [IW-1:0]          k_cur;

  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;
  assign rd_addr  = column;

  // Clamp the configured distance and row length into range
  always_comb begin
    if (bytes_per_pixel == '0) bpp_eff = psu_pkg::BPP_W'(1);
    else if (bytes_per_pixel > psu_pkg::BPP_W'(MAX_BPP)) bpp_eff = psu_pkg::BPP_W'(MAX_BPP);
    else bpp_eff = bytes_per_pixel;

    if (row_bytes == '0) len_eff = LW'(1);
    else if (LW'(row_bytes) > LW'(MAX_ROW_BYTES)) len_eff = LW'(MAX_ROW_BYTES);
    else len_eff = LW'(row_bytes);

    col_p1  = LW'(column) + LW'(1);
    is_last = (col_p1 >= len_eff);
  end

  // Column modulo each possible distance, kept as one wrap counter per distance
  always_comb begin
    k_cur = '0;
    for (int m = 1; m <= MAX_BPP; m++) begin
      if (bpp_eff == psu_pkg::BPP_W'(m)) k_cur = kcnt[m-1];
    end
  end

  always_comb begin
    column_next          = column;
    on_first_row_next    = on_first_row;
    row_filter_next      = row_filter;
    awaiting_filter_next = awaiting_filter;
    halted_next          = halted;
    keep                 = 1'b0;
    kclear               = 1'b0;
    kadv                 = 1'b0;
    op_new               = psu_pkg::OP_CLEAR;

    if (in_start || (!halted && awaiting_filter)) begin
      // Filter byte; start of image also restarts the image
      if (in_start) begin
        on_first_row_next = 1'b1;
        halted_next       = 1'b0;
      end
      column_next = '0;
      kclear      = 1'b1;
      keep        = 1'b1;
      if (in_byte > psu_pkg::BYTE_W'(psu_pkg::FILT_PAETH)) begin
        halted_next          = 1'b1;
        awaiting_filter_next = 1'b1;
        op_new               = psu_pkg::OP_ERROR;
      end else begin
        row_filter_next      = psu_pkg::filt_t'(in_byte[2:0]);
        awaiting_filter_next = 1'b0;
      end
    end else if (!halted) begin
      keep   = 1'b1;
      op_new = psu_pkg::OP_DATA;
      if (is_last) begin
        column_next          = '0;
        kclear               = 1'b1;
        awaiting_filter_next = 1'b1;
        on_first_row_next    = 1'b0;
      end else begin
        column_next = column + CW'(1);
        kadv        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column          <= '0;
      on_first_row    <= 1'b1;
      row_filter      <= psu_pkg::FILT_NONE;
      awaiting_filter <= 1'b1;
      halted          <= 1'b0;
      s1_valid        <= 1'b0;
      for (int m = 0; m < MAX_BPP; m++) kcnt[m] <= '0;
    end else begin
      if (accept) begin
        column          <= column_next;
        on_first_row    <= on_first_row_next;
        row_filter      <= row_filter_next;
        awaiting_filter <= awaiting_filter_next;
        halted          <= halted_next;
        s1_valid        <= keep;
        for (int m = 0; m < MAX_BPP; m++) begin
          if (kclear) kcnt[m] <= '0;
          else if (kadv) kcnt[m] <= (kcnt[m] == IW'(m)) ? '0 : kcnt[m] + IW'(1);
        end
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info.op     <= op_new;
      s1_info.filter <= row_filter;
      s1_info.first  <= on_first_row;
      s1_info.last   <= is_last;
      s1_k           <= k_cur;
      s1_col         <= column;
    end
  end

endmodule

`default_nettype wire

// File: rtl/psu_recon.sv
// Reconstruct stage: line store, left/upper-left histories and the predictor.
// Depends on psu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psu_recon #(
  parameter int MAX_ROW_BYTES = 4096,
  parameter int MAX_BPP       = 8,
  parameter int CW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1,
  parameter int IW = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            rd_en,
  input  wire  [CW-1:0]                  rd_addr,
  input  wire  [psu_pkg::BYTE_W-1:0]     in_byte,
  input  wire                            s1_valid,
  input  psu_pkg::psu_s1_t               s1_info,
  input  wire  [IW-1:0]                  s1_k,
  input  wire  [CW-1:0]                  s1_col,
  input  wire                            s1_adv,
  output logic                           res_want,
  output logic [psu_pkg::BYTE_W-1:0]     res_pixel,
  output logic                           res_last,
  output logic                           res_bad
);

  logic [psu_pkg::BYTE_W-1:0] line_mem [MAX_ROW_BYTES];
  logic [psu_pkg::BYTE_W-1:0] rd_data;
  logic [psu_pkg::BYTE_W-1:0] s1_raw;
  logic [psu_pkg::BYTE_W-1:0] left_hist [MAX_BPP];
  logic [psu_pkg::BYTE_W-1:0] up_hist   [MAX_BPP];

  logic [psu_pkg::BYTE_W-1:0] a, b, c, pred, val;
  logic [psu_pkg::BYTE_W:0]   ab_sum;
  logic                       is_data;

  // Read the byte above while the word enters the stage
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= line_mem[rd_addr];
      s1_raw  <= in_byte;
    end
    if (s1_adv && is_data) line_mem[s1_col] <= val;
  end

  always_comb begin
    is_data = (s1_info.op == psu_pkg::OP_DATA);
    a       = left_hist[s1_k];
    c       = up_hist[s1_k];
    b       = s1_info.first ? '0 : rd_data;
    ab_sum  = {1'b0, a} + {1'b0, b};
    case (s1_info.filter)
      psu_pkg::FILT_SUB:   pred = a;
      psu_pkg::FILT_UP:    pred = b;
      psu_pkg::FILT_AVG:   pred = ab_sum[psu_pkg::BYTE_W:1];
      psu_pkg::FILT_PAETH: pred = psu_pkg::paeth_pick(a, b, c);
      default:             pred = '0;
    endcase
    val       = s1_raw + pred;
    res_want  = s1_valid && (s1_info.op != psu_pkg::OP_CLEAR);
    res_pixel = is_data ? val : '0;
    res_last  = is_data && s1_info.last;
    res_bad   = (s1_info.op == psu_pkg::OP_ERROR);
  end

  // Histories: cleared by every filter byte, one entry updated per data byte
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_BPP; i++) begin
        left_hist[i] <= '0;
        up_hist[i]   <= '0;
      end
    end else if (s1_adv) begin
      if (is_data) begin
        left_hist[s1_k] <= val;
        up_hist[s1_k]   <= b;
      end else begin
        for (int i = 0; i < MAX_BPP; i++) begin
          left_hist[i] <= '0;
          up_hist[i]   <= '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/png_scanline_unfilter_unit.sv
// Top level of the PNG scanline unfilter: stream ports, APB registers, result register.
// Depends on psu_pkg, psu_front and psu_recon.
`timescale 1ns / 1ps
`default_nettype none

// Undoes PNG row filtering (None, Sub, Up, Average, Paeth) on an inflated byte
// stream. The first byte of each row is the filter type, followed by row_bytes
// filtered bytes; a word with s_tuser high starts a new image. One pixel byte
// comes out per data byte, with m_tlast on the last byte of each row. Filter
// bytes give no output; a filter type above 4 gives a single word with m_tuser
// high and zero data, after which input is dropped until the next image start.
// Throughput is one byte per clock while the sink keeps m_tready high, with no
// gaps at row boundaries. On the way to m_tvalid a word passes the stage register,
// which takes the line store's registered read of the byte above, and the result
// register, which takes the predictor and add. The line store holds MAX_ROW_BYTES
// bytes and needs no clearing pass; its data is used only on rows after the
// first, once written. Write bytes_per_pixel (address 0x0) and row_bytes (address
// 0x4) only while the stream is idle.

module png_scanline_unfilter_unit #(
  parameter int MAX_ROW_BYTES = 4096,
  parameter int MAX_BPP       = 8
) (
  input  wire         clk,
  input  wire         rst,
  // input stream
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,    // [7:0] data_byte
  input  wire         s_tuser,    // [0] start_of_image
  // output stream
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata,    // [7:0] pixel_byte
  output logic        m_tlast,    // last_in_row
  output logic        m_tuser,    // [0] bad_filter
  // configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int IW = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;

  logic [psu_pkg::BPP_W-1:0]  bytes_per_pixel;
  logic [psu_pkg::ROW_W-1:0]  row_bytes;

  logic                       accept;
  logic [CW-1:0]              rd_addr;
  logic                       s1_valid;
  psu_pkg::psu_s1_t           s1_info;
  logic [IW-1:0]              s1_k;
  logic [CW-1:0]              s1_col;
  logic                       s1_adv;
  logic                       res_want;
  logic [psu_pkg::BYTE_W-1:0] res_pixel;
  logic                       res_last;
  logic                       res_bad;
  logic                       out_free;

  // Register port: always ready, write lands at the access phase
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= psu_pkg::BPP_RESET;
      row_bytes       <= psu_pkg::ROW_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        psu_pkg::REG_BPP: bytes_per_pixel <= pwdata[psu_pkg::BPP_W-1:0];
        psu_pkg::REG_ROW: row_bytes       <= pwdata[psu_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      psu_pkg::REG_BPP: prdata = 32'(bytes_per_pixel);
      psu_pkg::REG_ROW: prdata = 32'(row_bytes);
      default:          prdata = '0;
    endcase
  end

  // Advance the stage when its word makes no result, or the result register frees up
  assign out_free = !m_tvalid || m_tready;
  assign s1_adv   = s1_valid && (!res_want || out_free);

  psu_front #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES),
    .MAX_BPP       (MAX_BPP)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .in_byte         (s_tdata),
    .in_start        (s_tuser),
    .bytes_per_pixel (bytes_per_pixel),
    .row_bytes       (row_bytes),
    .s1_adv          (s1_adv),
    .accept          (accept),
    .rd_addr         (rd_addr),
    .s1_valid        (s1_valid),
    .s1_info         (s1_info),
    .s1_k            (s1_k),
    .s1_col          (s1_col)
  );

  psu_recon #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES),
    .MAX_BPP       (MAX_BPP)
  ) u_recon (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr   (rd_addr),
    .in_byte   (s_tdata),
    .s1_valid  (s1_valid),
    .s1_info   (s1_info),
    .s1_k      (s1_k),
    .s1_col    (s1_col),
    .s1_adv    (s1_adv),
    .res_want  (res_want),
    .res_pixel (res_pixel),
    .res_last  (res_last),
    .res_bad   (res_bad)
  );

  // Result register: hold the word until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv && res_want) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_want) begin
      m_tdata <= res_pixel;
      m_tlast <= res_last;
      m_tuser <= res_bad;
    end
  end

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for png_scanline_unfilter_unit: directed and random byte
// streams, a prediction of every pixel word, and idle/stall phases.
// Depends on psu_pkg and the RTL of the unfilter unit; nothing else.
`timescale 1ns / 1ps

module testbench;

  localparam int LINE_DEPTH = 4096;     // line store depth of the unit
  localparam int HIST_DEPTH = 8;        // widest pixel, in bytes
  localparam int CYCLE_LIMIT = 400000;  // watchdog bound on the whole run
  localparam int SETTLE = 4;            // extra wait after draining, for a trailing filter byte

  // Expected pixel word, field by field
  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
    logic       bad;
  } pixel_word_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #4 clk = ~clk;

  // Stream and register ports; the driven ones are known from time zero
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [7:0] data_byte
  logic        s_tuser  = 1'b0; // [0] start_of_image
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // [7:0] pixel_byte
  logic        m_tlast;         // last_in_row
  logic        m_tuser;         // [0] bad_filter
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  png_scanline_unfilter_unit #(
    .MAX_ROW_BYTES(LINE_DEPTH),
    .MAX_BPP      (HIST_DEPTH)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // ---------------------------------------------------------------------------
  // Unfilter predictor: its own copy of the line store, the left and upper-left
  // histories, the row position and the two registers.
  // ---------------------------------------------------------------------------
  logic [7:0]                line_store [LINE_DEPTH];
  logic [7:0]                left_hist  [HIST_DEPTH];
  logic [7:0]                uleft_hist [HIST_DEPTH];
  int                        col;
  bit                        first_row;
  bit                        want_filter;
  bit                        stopped;
  psu_pkg::filt_t            cur_filter;
  logic [psu_pkg::BPP_W-1:0] cfg_bpp;
  logic [psu_pkg::ROW_W-1:0] cfg_row;

  pixel_word_t pending_pixels[$];   // predicted words not yet seen at the output

  // Run bookkeeping
  int errors       = 0;
  int words_sent   = 0;
  int words_seen   = 0;
  int row_ends     = 0;
  int filter_fails = 0;
  int cycles       = 0;
  int idle_pct     = 0;   // chance that the sender idles before a word
  int stall_pct    = 0;   // chance that the receiver drops tready in a cycle
  int hold_left    = 0;   // long receiver hold-off, counted down below

  function automatic logic [7:0] paeth_choice(int a, int b, int c);
    int est, da, db, dc;
    est = a + b - c;
    da = (est > a) ? est - a : a - est;
    db = (est > b) ? est - b : b - est;
    dc = (est > c) ? est - c : c - est;
    if (da <= db && da <= dc) return 8'(a);
    if (db <= dc) return 8'(b);
    return 8'(c);
  endfunction

  // Effective row length: zero acts as one, anything past the store as the store
  function automatic int row_len_now();
    if (cfg_row == 0) return 1;
    if (cfg_row > LINE_DEPTH) return LINE_DEPTH;
    return int'(cfg_row);
  endfunction

  // A filter byte clears the histories; a type past Paeth halts the image
  function automatic void take_filter(logic [7:0] code);
    pixel_word_t w;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      left_hist[i]  = '0;
      uleft_hist[i] = '0;
    end
    col = 0;
    if (code > 8'(psu_pkg::FILT_PAETH)) begin
      stopped = 1'b1;
      w.pixel = '0;
      w.last  = 1'b0;
      w.bad   = 1'b1;
      pending_pixels = {pending_pixels, w};
    end else begin
      cur_filter  = psu_pkg::filt_t'(code[2:0]);
      want_filter = 1'b0;
    end
  endfunction

  // Work out what one accepted input word produces
  function automatic void unfilter_byte(logic [7:0] raw, logic sof);
    int bpp, k, a, b, c, pred;
    pixel_word_t w;
    if (sof) begin
      stopped     = 1'b0;
      first_row   = 1'b1;
      want_filter = 1'b1;
      take_filter(raw);
      return;
    end
    if (stopped) return;
    if (want_filter) begin
      take_filter(raw);
      return;
    end
    bpp = (cfg_bpp == 0) ? 1 : (cfg_bpp > HIST_DEPTH) ? HIST_DEPTH : int'(cfg_bpp);
    k = col % bpp;
    a = int'(left_hist[k]);
    c = int'(uleft_hist[k]);
    b = first_row ? 0 : int'(line_store[col]);   // above row reads as zero on the first row
    case (cur_filter)
      psu_pkg::FILT_SUB:   pred = a;
      psu_pkg::FILT_UP:    pred = b;
      psu_pkg::FILT_AVG:   pred = (a + b) >> 1;
      psu_pkg::FILT_PAETH: pred = int'(paeth_choice(a, b, c));
      default:             pred = 0;
    endcase
    w.pixel = 8'(int'(raw) + pred);
    w.bad   = 1'b0;
    left_hist[k]    = w.pixel;
    uleft_hist[k]   = 8'(b);
    line_store[col] = w.pixel;
    if (col + 1 >= row_len_now()) begin
      w.last      = 1'b1;
      col         = 0;
      want_filter = 1'b1;
      first_row   = 1'b0;
    end else begin
      w.last = 1'b0;
      col++;
    end
    pending_pixels = {pending_pixels, w};
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver side: random tready, forced low while a hold-off is counting.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    m_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
  end

  // Count the hold-off down on its own
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Check every accepted output word against the oldest prediction
  always @(posedge clk) begin
    pixel_word_t exp_w;
    if (!rst && m_tvalid && m_tready) begin
      words_seen++;
      if (pending_pixels.size() == 0) begin
        $error("unexpected word: pixel_byte %0h last_in_row %0b bad_filter %0b",
               m_tdata, m_tlast, m_tuser);
        errors++;
      end else begin
        exp_w = pending_pixels.pop_front();
        if (exp_w.last) row_ends++;
        if (exp_w.bad) filter_fails++;
        if (m_tdata !== exp_w.pixel) begin
          $error("pixel_byte: expected %02h, got %02h", exp_w.pixel, m_tdata);
          errors++;
        end
        if (m_tlast !== exp_w.last) begin
          $error("last_in_row: expected %0b, got %0b", exp_w.last, m_tlast);
          errors++;
        end
        if (m_tuser !== exp_w.bad) begin
          $error("bad_filter: expected %0b, got %0b", exp_w.bad, m_tuser);
          errors++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still expected",
               cycles, pending_pixels.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers. Each is entered at a rising edge and leaves at one.
  // ---------------------------------------------------------------------------

  // Offer one input word, idling first at random; predict once it is taken
  task automatic send_word(logic [7:0] d, logic sof);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= sof;
    do @(posedge clk); while (!s_tready);
    words_sent++;
    unfilter_byte(d, sof);
  endtask

  // Drop tvalid, let every predicted word come out, then let the pipe settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready
  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[2] == psu_pkg::REG_ROW) cfg_row = data[psu_pkg::ROW_W-1:0];
    else cfg_bpp = data[psu_pkg::BPP_W-1:0];
  endtask

  // Write both registers once the unit is idle
  task automatic set_config(int bpp, int row);
    wait_drained();
    apb_write({psu_pkg::REG_BPP, 2'b00}, 32'(bpp));
    apb_write({psu_pkg::REG_ROW, 2'b00}, 32'(row));
  endtask

  function automatic logic [7:0] good_filter();
    return 8'($urandom_range(int'(psu_pkg::FILT_PAETH)));
  endfunction

  function automatic logic [7:0] bad_filter_code();
    return 8'($urandom_range(255, int'(psu_pkg::FILT_PAETH) + 1));
  endfunction

  // One image of random content; now and then broken by a bad filter type,
  // stray words after it, or a row cut short by the next start of image
  task automatic send_random_image();
    int rows, len, n;
    len  = row_len_now();
    rows = $urandom_range(4, 1);
    if ($urandom_range(99) < 3) begin
      send_word(bad_filter_code(), 1'b1);
      repeat ($urandom_range(3)) send_word(8'($urandom_range(255)), 1'b0);
      return;
    end
    send_word(good_filter(), 1'b1);
    for (int r = 0; r < rows; r++) begin
      if (r > 0) begin
        if ($urandom_range(99) < 4) begin
          send_word(bad_filter_code(), 1'b0);
          repeat ($urandom_range(3)) send_word(8'($urandom_range(255)), 1'b0);
          return;
        end
        send_word(good_filter(), 1'b0);
      end
      n = ($urandom_range(99) < 4) ? $urandom_range(len - 1) : len;
      repeat (n) send_word(8'($urandom_range(255)), 1'b0);
      if (n < len) return;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every filter type on rows after the first, at byte extremes
  task automatic test_each_filter();
    set_config(1, 3);
    send_word(8'(psu_pkg::FILT_UP), 1'b1);   // first row: Up acts as None
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'(psu_pkg::FILT_SUB), 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(8'(psu_pkg::FILT_UP), 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'(psu_pkg::FILT_AVG), 1'b0);
    send_word(8'hFE, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h33, 1'b0);
    send_word(8'(psu_pkg::FILT_PAETH), 1'b0);
    send_word(8'h10, 1'b0);
    send_word(8'hF0, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'(psu_pkg::FILT_NONE), 1'b0);
    send_word(8'hA5, 1'b0);
    send_word(8'h5A, 1'b0);
    send_word(8'h00, 1'b0);
    wait_drained();
  endtask

  // First row of an image: Average uses the left byte only, Paeth acts as Sub
  task automatic test_first_row_forms();
    set_config(2, 4);
    send_word(8'(psu_pkg::FILT_AVG), 1'b1);
    repeat (4) send_word(8'($urandom_range(255)), 1'b0);
    send_word(8'(psu_pkg::FILT_PAETH), 1'b1);
    repeat (4) send_word(8'($urandom_range(255)), 1'b0);
    wait_drained();
  endtask

  // Bad filter types at and after start of image; input is dropped until the
  // next start of image
  task automatic test_bad_filter();
    set_config(1, 2);
    send_word(8'(psu_pkg::FILT_NONE), 1'b1);
    send_word(8'h11, 1'b0);
    send_word(8'h22, 1'b0);
    send_word(8'hFF, 1'b0);                   // bad type mid image
    send_word(8'(psu_pkg::FILT_NONE), 1'b0);  // dropped while halted
    send_word(8'h44, 1'b0);
    send_word(8'd5, 1'b1);                    // smallest bad type, at start of image
    send_word(8'h55, 1'b0);
    send_word(8'(psu_pkg::FILT_SUB), 1'b1);   // recover
    send_word(8'h66, 1'b0);
    send_word(8'h77, 1'b0);
    wait_drained();
  endtask

  // Out-of-range registers: zero and fifteen bytes per pixel, zero row length
  task automatic test_register_extremes();
    set_config(0, 0);
    send_word(8'(psu_pkg::FILT_SUB), 1'b1);
    send_word(8'h81, 1'b0);
    send_word(8'(psu_pkg::FILT_PAETH), 1'b0);
    send_word(8'h7E, 1'b0);
    set_config(15, 20);
    send_word(8'(psu_pkg::FILT_SUB), 1'b1);
    repeat (20) send_word(8'($urandom_range(255)), 1'b0);
    send_word(8'(psu_pkg::FILT_PAETH), 1'b0);
    repeat (20) send_word(8'($urandom_range(255)), 1'b0);
    wait_drained();
  endtask

  // Registers rewritten in the middle of a row: bpp changes, row length drops
  task automatic test_mid_row_change();
    set_config(2, 8);
    send_word(8'(psu_pkg::FILT_SUB), 1'b1);
    repeat (3) send_word(8'($urandom_range(255)), 1'b0);
    set_config(5, 5);             // row now ends at the fifth byte
    repeat (2) send_word(8'($urandom_range(255)), 1'b0);
    send_word(8'(psu_pkg::FILT_PAETH), 1'b0);
    repeat (3) send_word(8'($urandom_range(255)), 1'b0);
    set_config(5, 2);             // already past the new end: next byte ends it
    send_word(8'($urandom_range(255)), 1'b0);
    send_word(8'(psu_pkg::FILT_AVG), 1'b0);
    repeat (2) send_word(8'($urandom_range(255)), 1'b0);
    wait_drained();
  endtask

  // Long rows at the widest pixel under light idling and stalling
  task automatic test_long_row();
    idle_pct  = 15;
    stall_pct = 15;
    set_config(8, 200);
    send_word(8'(psu_pkg::FILT_SUB), 1'b1);
    repeat (200) send_word(8'($urandom_range(255)), 1'b0);
    send_word(8'(psu_pkg::FILT_PAETH), 1'b0);
    repeat (200) send_word(8'($urandom_range(255)), 1'b0);
    wait_drained();
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_back_pressure();
    set_config(3, 9);
    send_word(8'(psu_pkg::FILT_AVG), 1'b1);
    hold_left <= 300;
    repeat (40) begin
      if (col == 0 && want_filter) send_word(good_filter(), 1'b0);
      else send_word(8'($urandom_range(255)), 1'b0);
    end
    wait_drained();
  endtask

  // Random images under one idle/stall setting; register settings change between batches
  task automatic test_random(int send_idle, int recv_stall, int count);
    int stop_at, batch_end, bpp, row;
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    stop_at   = words_sent + count;
    while (words_sent < stop_at) begin
      bpp = ($urandom_range(9) == 0) ? (($urandom_range(1) == 0) ? 0 : 15)
                                     : $urandom_range(8, 1);
      case ($urandom_range(9))
        0:       row = 1;
        1:       row = $urandom_range(100, 17);
        default: row = $urandom_range(16, 2);
      endcase
      set_config(bpp, row);
      batch_end = words_sent + 60;
      while (words_sent < batch_end && words_sent < stop_at) send_random_image();
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Predictor starts from the reset state; the line store is never read
    // before it is written, so its contents start as don't-care zeros
    for (int i = 0; i < LINE_DEPTH; i++) line_store[i] = '0;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      left_hist[i]  = '0;
      uleft_hist[i] = '0;
    end
    col         = 0;
    first_row   = 1'b1;
    want_filter = 1'b1;
    stopped     = 1'b0;
    cur_filter  = psu_pkg::FILT_NONE;
    cfg_bpp     = psu_pkg::BPP_RESET;
    cfg_row     = psu_pkg::ROW_RESET;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_each_filter();
    test_first_row_forms();
    test_bad_filter();
    test_register_extremes();
    test_mid_row_change();
    test_back_pressure();
    test_long_row();
    test_random(0, 0, 125);
    test_random(70, 0, 125);
    test_random(0, 70, 125);
    test_random(15, 15, 125);
    test_back_pressure();

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d input words; checked %0d output words, %0d row ends, %0d filter errors",
             words_sent, words_seen, row_ends, filter_fails);
    $display("All five filters, register extremes, mid-row rewrites, idle and stall phases");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
